/* rtl/core/smf_pkg.sv */
// smf_pkg: shared types and constants of the set median finder
// no dependencies; imported by every module of the block

package smf_pkg;

  // capacity of the sorting chain, one value per cell
  localparam int unsigned SMF_MAX_ELEMENTS = 64;
  // element count holds 0 .. SMF_MAX_ELEMENTS
  localparam int unsigned SMF_CNT_W = $clog2(SMF_MAX_ELEMENTS + 1);
  // shift count holds 0 .. (SMF_MAX_ELEMENTS - 1) / 2
  localparam int unsigned SMF_SH_W = (SMF_CNT_W > 1) ? SMF_CNT_W - 1 : 1;
  localparam int unsigned SMF_DATA_W = 32;

  // result status codes
  typedef enum logic [1:0] {
    SMF_ST_OK      = 2'd0,
    SMF_ST_EMPTY   = 2'd1,
    SMF_ST_DROPPED = 2'd2
  } smf_status_e;

  // input request
  typedef struct packed {
    logic signed [SMF_DATA_W-1:0] value;
    logic                         last;
  } smf_in_t;

  // result
  typedef struct packed {
    logic signed [SMF_DATA_W-1:0] median_value;
    smf_status_e                  status;
  } smf_out_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic                         insert;
    logic                         shift;
    logic signed [SMF_DATA_W-1:0] value;
  } smf_cell_ctrl_t;

endpackage

/* rtl/core/set_median_finder.sv */
// set_median_finder: median of a set of signed values through an insertion chain
// depends on smf_pkg and smf_cell
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one signed
//   32-bit value per request, with last marking the end of a set. Values are
//   sorted on arrival by a row of SMF_MAX_ELEMENTS cells, one value a cycle
//   while in_stall_o is low. Values arriving once the chain is full are
//   dropped and reported. After the last request the chain shifts towards
//   cell zero until the middle value sits in cell zero, or the two middle
//   values in cells zero and one; then the 33-bit sum is registered and the
//   result is loaded from it once the output register is free.
//   While the median is worked out in_stall_o is high; the chain then takes
//   the next set at one value per cycle.
//   Output channel (out_valid_o / out_stall_i / out_data_o) holds one result
//   per set in an output register; a stalled result stays put, and the next
//   set may load while it waits, its own result waiting until the register
//   frees up.
//   Reset (rst_ni low, asynchronous) clears the count, the overflow flag, the
//   sequencer and the output valid; the cell contents need no reset.

module set_median_finder
  import smf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  smf_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output smf_out_t out_data_o
);

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_SHIFT = 3'b010,
    ST_DONE  = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic [SMF_CNT_W-1:0]   count_q, count_d;
  logic                   ovf_q, ovf_d;
  logic [SMF_SH_W-1:0]    shcnt_q, shcnt_d;
  logic signed [SMF_DATA_W:0] sum_q, sum_d;
  logic                   out_valid_q, out_valid_d;
  smf_out_t               out_q, out_d;

  logic                   in_acc;
  logic                   room;
  logic [SMF_CNT_W-1:0]   n_new;
  logic [SMF_CNT_W-1:0]   n_m1;
  logic                   out_free;
  logic signed [SMF_DATA_W:0] half_sum;

  smf_cell_ctrl_t                 cell_ctrl;
  logic [SMF_MAX_ELEMENTS-1:0]    occ;
  logic [SMF_MAX_ELEMENTS-1:0]    gt;
  logic signed [SMF_DATA_W-1:0]   cell_data [SMF_MAX_ELEMENTS];

  assign in_stall_o = (state_q != ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign room       = (count_q != SMF_CNT_W'(SMF_MAX_ELEMENTS));
  assign n_new      = count_q + SMF_CNT_W'(room);
  assign n_m1       = n_new - SMF_CNT_W'(1);
  assign out_free   = !out_valid_q || !out_stall_i;

  // chain control
  always_comb begin
    cell_ctrl.insert = in_acc && room;
    cell_ctrl.shift  = (state_q == ST_SHIFT) && (shcnt_q != '0);
    cell_ctrl.value  = in_data_i.value;
  end

  // row of sorting cells
  for (genvar i = 0; i < SMF_MAX_ELEMENTS; i++) begin : g_cell
    assign occ[i] = (count_q > SMF_CNT_W'(i));
    if (i == 0) begin : g_first
      smf_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (cell_ctrl),
        .occ_i       (occ[i]),
        .prev_occ_i  (1'b1),
        .prev_gt_i   (1'b0),
        .prev_data_i ('0),
        .next_data_i (cell_data[(i + 1) % SMF_MAX_ELEMENTS]),
        .gt_o        (gt[i]),
        .data_o      (cell_data[i])
      );
    end else if (i == SMF_MAX_ELEMENTS - 1) begin : g_end
      smf_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (cell_ctrl),
        .occ_i       (occ[i]),
        .prev_occ_i  (occ[i-1]),
        .prev_gt_i   (gt[i-1]),
        .prev_data_i (cell_data[i-1]),
        .next_data_i (cell_data[i]),
        .gt_o        (gt[i]),
        .data_o      (cell_data[i])
      );
    end else begin : g_mid
      smf_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (cell_ctrl),
        .occ_i       (occ[i]),
        .prev_occ_i  (occ[i-1]),
        .prev_gt_i   (gt[i-1]),
        .prev_data_i (cell_data[i-1]),
        .next_data_i (cell_data[i+1]),
        .gt_o        (gt[i]),
        .data_o      (cell_data[i])
      );
    end
  end

  // halve the sum, rounding towards zero
  assign half_sum = sum_q + (SMF_DATA_W + 1)'(sum_q[SMF_DATA_W]);

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    shcnt_d     = shcnt_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          count_d = n_new;
          if (!room) begin
            ovf_d = 1'b1;
          end
          if (in_data_i.last) begin
            shcnt_d = SMF_SH_W'(n_m1 >> 1);
            state_d = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        if (shcnt_q != '0) begin
          shcnt_d = shcnt_q - SMF_SH_W'(1);
        end else begin
          // odd count doubles the middle value so the halving returns it
          if (count_q[0]) begin
            sum_d = (SMF_DATA_W + 1)'(cell_data[0]) + (SMF_DATA_W + 1)'(cell_data[0]);
          end else begin
            sum_d = (SMF_DATA_W + 1)'(cell_data[0]) + (SMF_DATA_W + 1)'(cell_data[1]);
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (count_q == '0) begin
            out_d.median_value = '0;
            out_d.status       = SMF_ST_EMPTY;
          end else begin
            out_d.median_value = half_sum[SMF_DATA_W:1];
            out_d.status       = ovf_q ? SMF_ST_DROPPED : SMF_ST_OK;
          end
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      shcnt_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      shcnt_q     <= shcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/core/smf_cell.sv */
// smf_cell: one cell of the insertion sorting chain
// depends on smf_pkg; instantiated in a row by set_median_finder

module smf_cell
  import smf_pkg::*;
(
  input  logic                         clk_i,
  input  smf_cell_ctrl_t               ctrl_i,
  input  logic                         occ_i,
  input  logic                         prev_occ_i,
  input  logic                         prev_gt_i,
  input  logic signed [SMF_DATA_W-1:0] prev_data_i,
  input  logic signed [SMF_DATA_W-1:0] next_data_i,
  output logic                         gt_o,
  output logic signed [SMF_DATA_W-1:0] data_o
);

  logic signed [SMF_DATA_W-1:0] data_q, data_d;
  logic                         tail;

  // held value is larger than the incoming one, so it moves up
  assign gt_o = occ_i && (data_q > ctrl_i.value);
  // first free cell of the chain
  assign tail = prev_occ_i && !occ_i;

  // insert: take the lower neighbour's value, the new value, or keep
  // shift: move one place towards cell zero
  always_comb begin
    data_d = data_q;
    if (ctrl_i.insert) begin
      if (prev_gt_i) begin
        data_d = prev_data_i;
      end else if (gt_o || tail) begin
        data_d = ctrl_i.value;
      end
    end else if (ctrl_i.shift) begin
      data_d = next_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* rtl/core/smf_checker.sv */
// smf_checker: port-level checks of set_median_finder
// depends on smf_pkg; attached to the top level by the bind below

module smf_checker
  import smf_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input smf_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input smf_out_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // the end of a set makes the block busy
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last |=> in_stall_o)
    else $error("no busy phase after last request");

  // a new result appears only at the end of a busy phase
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without median phase");

  // empty set reports zero
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == SMF_ST_EMPTY) |-> out_data_o.median_value == '0)
    else $error("empty set with non-zero median");

endmodule

bind set_median_finder smf_checker u_smf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
